// ===== src/tcc_pkg.sv =====
// Package for the triangle circumcircle pipeline: widths, stage records and helpers.
// Depends on nothing; used by the interfaces and the top level.
`timescale 1ns / 1ps
package tcc_pkg;

  localparam int CW  = 16;  // corner coordinate, Q8.8
  localparam int DFW = 17;  // coordinate difference
  localparam int PW  = 33;  // corner product / squared norm
  localparam int DW  = 36;  // D = 2 * sum of products
  localparam int XW  = 50;  // squared norm times difference
  localparam int NW  = 51;  // numerator, also quotient width
  localparam int OW  = 32;  // result field width
  localparam int RW  = 32;  // square root bits
  localparam int SW  = 64;  // squared radius
  localparam int RMW = 36;  // root remainder
  // input/register stages + divider + rounding + root + output
  localparam int NV  = 5 + NW + 5 + RW + 1;

  localparam logic [NW-1:0] QNEG_LIM = NW'(64'h8000_0000);
  localparam logic [NW-1:0] QPOS_LIM = NW'(64'h7FFF_FFFF);
  localparam logic [OW-1:0] SAT_NEG  = 32'h8000_0000;
  localparam logic [OW-1:0] SAT_POS  = 32'h7FFF_FFFF;
  localparam logic [OW-1:0] RAD_MAX  = 32'hFFFF_FFFF;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic [NW-1:0] num;
    logic [NW-1:0] quo;
    logic [DW:0]   rem;
  } div_t;

  typedef struct packed {
    logic [DW-1:0] den;
    logic          negx;
    logic          negy;
    logic          degen;
    coord_t        ax;
    coord_t        ay;
  } side_t;

  typedef struct packed {
    logic [SW-1:0]  val;
    logic [RW-1:0]  root;
    logic [RMW-1:0] rem;
  } sq_t;

  typedef struct packed {
    logic [OW-1:0] cx;
    logic [OW-1:0] cy;
    logic          sat;
    logic          degen;
  } tail_t;

  function automatic logic [OW-1:0] sat_center(input logic neg, input logic [NW-1:0] q);
    logic [NW-1:0] nq;
    nq = -q;
    if (neg) begin
      sat_center = (q > QNEG_LIM) ? SAT_NEG : nq[OW-1:0];
    end else begin
      sat_center = (q > QPOS_LIM) ? SAT_POS : q[OW-1:0];
    end
  endfunction

endpackage

// ===== src/tcc_if.sv =====
// Request channels of the circumcircle block: corner triple in, circle out.
// Depends on tcc_pkg.
`timescale 1ns / 1ps
interface tcc_in_if;
  import tcc_pkg::*;
  logic   valid;
  logic   ready;
  coord_t a_x;
  coord_t a_y;
  coord_t b_x;
  coord_t b_y;
  coord_t c_x;
  coord_t c_y;
  modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, input ready);
  modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, output ready);
endinterface

interface tcc_out_if;
  import tcc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] center_x;
  logic signed [OW-1:0] center_y;
  logic [OW-1:0]        radius;
  logic                 degenerate;
  modport source (output valid, center_x, center_y, radius, degenerate, input ready);
  modport sink   (input valid, center_x, center_y, radius, degenerate, output ready);
endinterface

// ===== src/triangle_circumcircle.sv =====
// Circumcircle of a 2-D triangle: centre (Q24.8, saturated) and radius (Q24.8).
// One request per cycle is accepted while the pipeline is not stalled.
// The depth is set by the 51-stage restoring divider and the 32-stage square root.
// The whole pipeline stalls as one while the output register holds an untaken result.
// Reset clears the valid bits only; the data registers are not reset.
`timescale 1ns / 1ps
module triangle_circumcircle (
  input  logic clk_i,
  input  logic rst_ni,
  tcc_in_if.sink    in_i,
  tcc_out_if.source out_o
);
  import tcc_pkg::*;

  logic          en;
  logic [NV-1:0] v_q;

  // stage 1: corners and differences
  coord_t                ax1_q, ay1_q, bx1_q, by1_q, cx1_q, cy1_q;
  logic signed [DFW-1:0] dy1_q, dy2_q, dy3_q, dx1_q, dx2_q, dx3_q;
  // stage 2: products for D, squared norms
  logic signed [PW-1:0]  p1_q, p2_q, p3_q, sa_q, sb_q, sc_q;
  logic signed [DFW-1:0] dy1b_q, dy2b_q, dy3b_q, dx1b_q, dx2b_q, dx3b_q;
  coord_t                ax2_q, ay2_q;
  logic signed [2*CW-1:0] sq_ax, sq_ay, sq_bx, sq_by, sq_cx, sq_cy;
  // stage 3
  logic signed [DW-2:0]  dsum;
  logic signed [DW-1:0]  d3_q;
  logic signed [XW-1:0]  nx1_q, nx2_q, nx3_q, ny1_q, ny2_q, ny3_q;
  coord_t                ax3_q, ay3_q;
  // stage 4
  logic signed [NW-1:0]  nx4_q, ny4_q;
  logic signed [DW-1:0]  d4_q;
  coord_t                ax4_q, ay4_q;
  // divider
  div_t  divx_q [NW+1];
  div_t  divy_q [NW+1];
  side_t side_q [NW+1];
  // rounding and radius prep
  logic [NW-1:0]         qx_q, qy_q;
  side_t                 r1_q;
  logic signed [DW-1:0]  ddx_q, ddy_q;
  logic signed [NW:0]    ex, ey;
  logic [OW-1:0]         cx2_q, cy2_q, cx3_q, cy3_q, cx4_q, cy4_q;
  logic                  far2_q, sat3_q, sat4_q;
  logic                  dg2_q, dg3_q, dg4_q;
  logic [DW-1:0]         adx, ady;
  logic [RW-1:0]         adx3_q, ady3_q;
  logic [SW-1:0]         sqx4_q, sqy4_q;
  logic [SW:0]           ssum;
  // square root
  sq_t   sq_q   [RW+1];
  tail_t tail_q [RW+1];
  // output
  logic [RW:0]           rnd;
  logic [OW-1:0]         ocx_q, ocy_q, orad_q;
  logic                  odg_q;

  assign en         = ~v_q[NV-1] | out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NV-2:0], in_i.valid};
    end
  end

  assign sq_ax = ax1_q * ax1_q;
  assign sq_ay = ay1_q * ay1_q;
  assign sq_bx = bx1_q * bx1_q;
  assign sq_by = by1_q * by1_q;
  assign sq_cx = cx1_q * cx1_q;
  assign sq_cy = cy1_q * cy1_q;
  assign dsum  = (DW-1)'(p1_q) + (DW-1)'(p2_q) + (DW-1)'(p3_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q <= in_i.a_x;  ay1_q <= in_i.a_y;
      bx1_q <= in_i.b_x;  by1_q <= in_i.b_y;
      cx1_q <= in_i.c_x;  cy1_q <= in_i.c_y;
      dy1_q <= DFW'(in_i.c_y) - DFW'(in_i.b_y);
      dy2_q <= DFW'(in_i.a_y) - DFW'(in_i.c_y);
      dy3_q <= DFW'(in_i.b_y) - DFW'(in_i.a_y);
      dx1_q <= DFW'(in_i.b_x) - DFW'(in_i.c_x);
      dx2_q <= DFW'(in_i.c_x) - DFW'(in_i.a_x);
      dx3_q <= DFW'(in_i.a_x) - DFW'(in_i.b_x);

      p1_q <= ax1_q * dy1_q;
      p2_q <= bx1_q * dy2_q;
      p3_q <= cx1_q * dy3_q;
      sa_q <= PW'(sq_ax) + PW'(sq_ay);
      sb_q <= PW'(sq_bx) + PW'(sq_by);
      sc_q <= PW'(sq_cx) + PW'(sq_cy);
      dy1b_q <= dy1_q;  dy2b_q <= dy2_q;  dy3b_q <= dy3_q;
      dx1b_q <= dx1_q;  dx2b_q <= dx2_q;  dx3b_q <= dx3_q;
      ax2_q <= ax1_q;   ay2_q <= ay1_q;

      d3_q  <= {dsum, 1'b0};
      nx1_q <= sa_q * dy1b_q;
      nx2_q <= sb_q * dy2b_q;
      nx3_q <= sc_q * dy3b_q;
      ny1_q <= sa_q * dx1b_q;
      ny2_q <= sb_q * dx2b_q;
      ny3_q <= sc_q * dx3b_q;
      ax3_q <= ax2_q;   ay3_q <= ay2_q;

      nx4_q <= NW'(nx1_q) + NW'(nx2_q) + NW'(nx3_q);
      ny4_q <= NW'(ny1_q) + NW'(ny2_q) + NW'(ny3_q);
      d4_q  <= d3_q;
      ax4_q <= ax3_q;   ay4_q <= ay3_q;

      // magnitudes and signs into the dividers
      divx_q[0].num   <= nx4_q[NW-1] ? NW'(-nx4_q) : NW'(nx4_q);
      divy_q[0].num   <= ny4_q[NW-1] ? NW'(-ny4_q) : NW'(ny4_q);
      divx_q[0].quo   <= '0;
      divy_q[0].quo   <= '0;
      divx_q[0].rem   <= '0;
      divy_q[0].rem   <= '0;
      side_q[0].den   <= d4_q[DW-1] ? DW'(-d4_q) : DW'(d4_q);
      side_q[0].negx  <= nx4_q[NW-1] ^ d4_q[DW-1];
      side_q[0].negy  <= ny4_q[NW-1] ^ d4_q[DW-1];
      side_q[0].degen <= (d4_q == '0);
      side_q[0].ax    <= ax4_q;
      side_q[0].ay    <= ay4_q;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < NW; i++) begin : g_div
    logic [DW:0] shx, shy;
    logic        gex, gey;
    assign shx = {divx_q[i].rem[DW-1:0], divx_q[i].num[NW-1-i]};
    assign shy = {divy_q[i].rem[DW-1:0], divy_q[i].num[NW-1-i]};
    assign gex = shx >= {1'b0, side_q[i].den};
    assign gey = shy >= {1'b0, side_q[i].den};
    always_ff @(posedge clk_i) begin
      if (en) begin
        divx_q[i+1].num <= divx_q[i].num;
        divy_q[i+1].num <= divy_q[i].num;
        divx_q[i+1].quo <= {divx_q[i].quo[NW-2:0], gex};
        divy_q[i+1].quo <= {divy_q[i].quo[NW-2:0], gey};
        divx_q[i+1].rem <= gex ? shx - {1'b0, side_q[i].den} : shx;
        divy_q[i+1].rem <= gey ? shy - {1'b0, side_q[i].den} : shy;
        side_q[i+1]     <= side_q[i];
      end
    end
  end

  assign ex   = r1_q.negx ? -(NW+1)'(qx_q) : (NW+1)'(qx_q);
  assign ey   = r1_q.negy ? -(NW+1)'(qy_q) : (NW+1)'(qy_q);
  assign adx  = ddx_q[DW-1] ? DW'(-ddx_q) : DW'(ddx_q);
  assign ady  = ddy_q[DW-1] ? DW'(-ddy_q) : DW'(ddy_q);
  assign ssum = (SW+1)'(sqx4_q) + (SW+1)'(sqy4_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // round half away from zero: up when twice the remainder reaches the divisor
      qx_q <= divx_q[NW].quo
            + NW'({divx_q[NW].rem, 1'b0} >= (DW+2)'(side_q[NW].den));
      qy_q <= divy_q[NW].quo
            + NW'({divy_q[NW].rem, 1'b0} >= (DW+2)'(side_q[NW].den));
      r1_q <= side_q[NW];

      cx2_q  <= sat_center(r1_q.negx, qx_q);
      cy2_q  <= sat_center(r1_q.negy, qy_q);
      far2_q <= (qx_q[NW-1:33] != '0) || (qy_q[NW-1:33] != '0);
      ddx_q  <= DW'(ex) - DW'(r1_q.ax);
      ddy_q  <= DW'(ey) - DW'(r1_q.ay);
      dg2_q  <= r1_q.degen;

      adx3_q <= adx[RW-1:0];
      ady3_q <= ady[RW-1:0];
      sat3_q <= far2_q || (adx[DW-1:RW] != '0) || (ady[DW-1:RW] != '0);
      cx3_q  <= cx2_q;  cy3_q <= cy2_q;  dg3_q <= dg2_q;

      sqx4_q <= adx3_q * adx3_q;
      sqy4_q <= ady3_q * ady3_q;
      sat4_q <= sat3_q;
      cx4_q  <= cx3_q;  cy4_q <= cy3_q;  dg4_q <= dg3_q;

      sq_q[0].val     <= ssum[SW-1:0];
      sq_q[0].root    <= '0;
      sq_q[0].rem     <= '0;
      tail_q[0].cx    <= cx4_q;
      tail_q[0].cy    <= cy4_q;
      tail_q[0].sat   <= sat4_q | ssum[SW];
      tail_q[0].degen <= dg4_q;
    end
  end

  // digit-by-digit square root, two radicand bits per stage
  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    logic [RMW-1:0] sh, trial;
    logic           ge;
    assign sh    = {sq_q[i].rem[RMW-3:0], sq_q[i].val[SW-1-2*i -: 2]};
    assign trial = RMW'({sq_q[i].root, 2'b01});
    assign ge    = sh >= trial;
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[i+1].val  <= sq_q[i].val;
        sq_q[i+1].root <= {sq_q[i].root[RW-2:0], ge};
        sq_q[i+1].rem  <= ge ? sh - trial : sh;
        tail_q[i+1]    <= tail_q[i];
      end
    end
  end

  // round to nearest: up when the remainder exceeds the root
  assign rnd = (RW+1)'(sq_q[RW].root) + (RW+1)'(sq_q[RW].rem > RMW'(sq_q[RW].root));

  always_ff @(posedge clk_i) begin
    if (en) begin
      odg_q <= tail_q[RW].degen;
      if (tail_q[RW].degen) begin
        ocx_q  <= '0;
        ocy_q  <= '0;
        orad_q <= '0;
      end else begin
        ocx_q  <= tail_q[RW].cx;
        ocy_q  <= tail_q[RW].cy;
        orad_q <= (tail_q[RW].sat || rnd[RW]) ? RAD_MAX : rnd[RW-1:0];
      end
    end
  end

  assign out_o.valid      = v_q[NV-1];
  assign out_o.center_x   = ocx_q;
  assign out_o.center_y   = ocy_q;
  assign out_o.radius     = orad_q;
  assign out_o.degenerate = odg_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.degenerate |->
      out_o.center_x == '0 && out_o.center_y == '0 && out_o.radius == '0)
    else $error("collinear result with nonzero fields");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("valid chain moved during stall");

  a_stall_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(orad_q) && $stable(ocx_q) && $stable(odg_q))
    else $error("output register changed during stall");

endmodule
